### rtl/core/arpt_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive ROI parameter tuner package
// Shared types, register indexes, thresholds, bounds and saturating helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package arpt_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_TUNER_ENABLE   = 2'd0;
  localparam logic [1:0] REG_DYNAMIC_ENABLE = 2'd1;
  localparam logic [1:0] REG_MIN_GAP_US     = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [23:0] MIN_GAP_RESET = 24'd1200000;

  // Classification thresholds (tenths of ms / tenths of a percent)
  localparam logic [15:0] LAT_HIGH     = 16'd950;
  localparam logic [15:0] LAT_LOW      = 16'd550;
  localparam logic [9:0]  CPU_HIGH     = 10'd820;
  localparam logic [9:0]  CPU_LOW      = 10'd580;
  localparam logic [7:0]  QUEUE_HIGH   = 8'd1;
  localparam logic [9:0]  HIT_UNSTABLE = 10'd220;
  localparam logic [7:0]  FB_UNSTABLE  = 8'd8;
  localparam logic [9:0]  AREA_BIG     = 10'd580;
  localparam logic [9:0]  HIT_GOOD     = 10'd600;
  localparam logic [9:0]  AREA_GOOD    = 10'd360;
  localparam logic [9:0]  AREA_SMALL   = 10'd280;
  localparam logic [9:0]  HIT_SMALL    = 10'd450;

  // Steps and bounds, all on an 11-bit working width
  localparam logic [10:0] STEP_ONE      = 11'd1;
  localparam logic [10:0] STEP_CONF_UP  = 11'd30;
  localparam logic [10:0] STEP_CONF     = 11'd20;
  localparam logic [10:0] STEP_AREA_DN  = 11'd20;
  localparam logic [10:0] STEP_AREA_UP  = 11'd10;
  localparam logic [10:0] CONF_GAP      = 11'd80;
  localparam logic [10:0] HOLD_FLOOR    = 11'd4;

  localparam logic [10:0] STRIDE_MIN  = 11'd2;
  localparam logic [10:0] STRIDE_MAX  = 11'd8;
  localparam logic [10:0] COARSE_MIN  = 11'd1;
  localparam logic [10:0] COARSE_MAX  = 11'd6;
  localparam logic [10:0] REFINE_MIN  = 11'd1;
  localparam logic [10:0] REFINE_MAX  = 11'd5;
  localparam logic [10:0] REUSE_MIN   = 11'd1;
  localparam logic [10:0] REUSE_MAX   = 11'd8;
  localparam logic [10:0] PAD_MIN     = 11'd2;
  localparam logic [10:0] PAD_MAX     = 11'd28;
  localparam logic [10:0] HOLD_MIN    = 11'd2;
  localparam logic [10:0] HOLD_MAX    = 11'd20;
  localparam logic [10:0] HITS_MIN    = 11'd3;
  localparam logic [10:0] HITS_MAX    = 11'd48;
  localparam logic [10:0] CHIGH_MIN   = 11'd550;
  localparam logic [10:0] CHIGH_MAX   = 11'd950;
  localparam logic [10:0] CLOW_MIN    = 11'd200;
  localparam logic [10:0] CLOW_MAX    = 11'd850;
  localparam logic [10:0] AREA_MIN    = 11'd200;
  localparam logic [10:0] AREA_MAX    = 11'd800;

  typedef struct packed {
    logic [47:0] time_us;
    logic        source_enabled;
    logic [15:0] latency_tenths_ms;
    logic [9:0]  cpu_tenths_pct;
    logic [7:0]  queue_level;
    logic [9:0]  hit_tenths_pct;
    logic [7:0]  fallback_count;
    logic [9:0]  area_tenths_pct;
  } arpt_in_t;

  typedef struct packed {
    logic       applied;
    logic [3:0] stride;
    logic [2:0] coarse_every;
    logic [2:0] refine_every;
    logic [3:0] reuse_limit;
    logic [4:0] pad_pixels;
    logic [4:0] hold_frames;
    logic [5:0] min_hit_count;
    logic [9:0] conf_high;
    logic [9:0] conf_low;
    logic [9:0] max_area;
  } arpt_out_t;

  typedef struct packed {
    logic [3:0] stride;
    logic [2:0] coarse_every;
    logic [2:0] refine_every;
    logic [3:0] reuse_limit;
    logic [4:0] pad_pixels;
    logic [4:0] hold_frames;
    logic [5:0] min_hit_count;
    logic [9:0] conf_high;
    logic [9:0] conf_low;
    logic [9:0] max_area;
  } arpt_vals_t;

  localparam arpt_vals_t VALS_RESET = '{
    stride:        4'd4,
    coarse_every:  3'd2,
    refine_every:  3'd2,
    reuse_limit:   4'd3,
    pad_pixels:    5'd10,
    hold_frames:   5'd8,
    min_hit_count: 6'd6,
    conf_high:     10'd780,
    conf_low:      10'd380,
    max_area:      10'd450
  };

  typedef struct packed {
    logic        tuner_enable;
    logic        dynamic_enable;
    logic [23:0] min_gap_us;
  } arpt_cfg_t;

  // Outcome of the gate and the classification of one event
  typedef struct packed {
    logic apply;
    logic p_high;
    logic p_low;
    logic unstable;
    logic good;
    logic too_big;
    logic small_roi;
  } arpt_class_t;

  function automatic logic [10:0] sat11(input logic [10:0] v, input logic [10:0] lo,
                                        input logic [10:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [10:0] step_up(input logic [10:0] v, input logic [10:0] step,
                                          input logic [10:0] lo, input logic [10:0] hi);
    logic [11:0] sum;
    sum = {1'b0, v} + {1'b0, step};
    if (sum < {1'b0, lo}) return lo;
    if (sum > {1'b0, hi}) return hi;
    return sum[10:0];
  endfunction

  function automatic logic [10:0] step_down(input logic [10:0] v, input logic [10:0] step,
                                            input logic [10:0] lo, input logic [10:0] hi);
    logic [10:0] diff;
    diff = (v > step) ? (v - step) : 11'd0;
    return sat11(diff, lo, hi);
  endfunction

endpackage

`default_nettype wire

### rtl/core/arpt_classify.sv
// ----------------------------------------------------------------------------
// ARPT event classifier
// Gates an event on the enables and the minimum tune gap, and sorts it by
// pressure and ROI quality.
// ----------------------------------------------------------------------------
`default_nettype none

module arpt_classify (
  input  arpt_pkg::arpt_cfg_t   cfg_i,
  input  logic [47:0]           last_time_i,
  input  arpt_pkg::arpt_in_t    item_i,
  output arpt_pkg::arpt_class_t cls_o
);

  logic [47:0] elapsed;
  logic        gap_ok;
  logic        enabled;

  assign elapsed = item_i.time_us - last_time_i;

  // A zero last time means never tuned: skip the gap check
  assign gap_ok = (last_time_i == 48'd0) ||
                  ((item_i.time_us >= last_time_i) &&
                   (elapsed >= {24'd0, cfg_i.min_gap_us}));

  assign enabled = cfg_i.tuner_enable & cfg_i.dynamic_enable & item_i.source_enabled;

  always_comb begin
    cls_o.apply    = enabled & gap_ok;
    cls_o.p_high   = (item_i.latency_tenths_ms > arpt_pkg::LAT_HIGH) ||
                     (item_i.cpu_tenths_pct > arpt_pkg::CPU_HIGH) ||
                     (item_i.queue_level > arpt_pkg::QUEUE_HIGH);
    cls_o.p_low    = (item_i.latency_tenths_ms < arpt_pkg::LAT_LOW) &&
                     (item_i.cpu_tenths_pct < arpt_pkg::CPU_LOW) &&
                     (item_i.queue_level == 8'd0);
    cls_o.unstable = (item_i.hit_tenths_pct < arpt_pkg::HIT_UNSTABLE) ||
                     (item_i.fallback_count >= arpt_pkg::FB_UNSTABLE);
    cls_o.too_big  = item_i.area_tenths_pct > arpt_pkg::AREA_BIG;
    cls_o.good     = (item_i.hit_tenths_pct > arpt_pkg::HIT_GOOD) &&
                     (item_i.area_tenths_pct != 10'd0) &&
                     (item_i.area_tenths_pct < arpt_pkg::AREA_GOOD);
    cls_o.small_roi = (item_i.area_tenths_pct != 10'd0) &&
                      (item_i.area_tenths_pct < arpt_pkg::AREA_SMALL) &&
                      (item_i.hit_tenths_pct > arpt_pkg::HIT_SMALL);
  end

endmodule

`default_nettype wire

### rtl/core/arpt_state.sv
// ----------------------------------------------------------------------------
// ARPT tuning state
// Holds the ten tuning values and the last tune time, and steps the values
// for one classified event.
// ----------------------------------------------------------------------------
`default_nettype none

module arpt_state (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  upd_en_i,
  input  arpt_pkg::arpt_class_t cls_i,
  input  logic [47:0]           time_i,
  output logic [47:0]           last_time_o,
  output arpt_pkg::arpt_vals_t  vals_next_o
);

  arpt_pkg::arpt_vals_t vals_q, vals_d;
  logic [47:0]          last_time_q;
  logic                 commit;

  logic [10:0] stride, coarse, refine, reuse, pad, hold, hits, chigh, clow, area;

  assign commit = upd_en_i & cls_i.apply;

  always_comb begin
    stride = 11'(vals_q.stride);
    coarse = 11'(vals_q.coarse_every);
    refine = 11'(vals_q.refine_every);
    reuse  = 11'(vals_q.reuse_limit);
    pad    = 11'(vals_q.pad_pixels);
    hold   = 11'(vals_q.hold_frames);
    hits   = 11'(vals_q.min_hit_count);
    chigh  = 11'(vals_q.conf_high);
    clow   = 11'(vals_q.conf_low);
    area   = 11'(vals_q.max_area);

    // Pressure: coarsen under load, refine when idle and the ROI is good
    if (cls_i.p_high) begin
      stride = arpt_pkg::step_up(stride, arpt_pkg::STEP_ONE, arpt_pkg::STRIDE_MIN,
                                 arpt_pkg::STRIDE_MAX);
      coarse = arpt_pkg::step_up(coarse, arpt_pkg::STEP_ONE, arpt_pkg::COARSE_MIN,
                                 arpt_pkg::COARSE_MAX);
      refine = arpt_pkg::step_up(refine, arpt_pkg::STEP_ONE, arpt_pkg::REFINE_MIN,
                                 arpt_pkg::REFINE_MAX);
      pad    = arpt_pkg::step_down(pad, arpt_pkg::STEP_ONE, arpt_pkg::PAD_MIN,
                                   arpt_pkg::PAD_MAX);
      reuse  = arpt_pkg::step_up(reuse, arpt_pkg::STEP_ONE, arpt_pkg::REUSE_MIN,
                                 arpt_pkg::REUSE_MAX);
    end else if (cls_i.p_low && cls_i.good) begin
      stride = arpt_pkg::step_down(stride, arpt_pkg::STEP_ONE, arpt_pkg::STRIDE_MIN,
                                   arpt_pkg::STRIDE_MAX);
      coarse = arpt_pkg::step_down(coarse, arpt_pkg::STEP_ONE, arpt_pkg::COARSE_MIN,
                                   arpt_pkg::COARSE_MAX);
      refine = arpt_pkg::step_down(refine, arpt_pkg::STEP_ONE, arpt_pkg::REFINE_MIN,
                                   arpt_pkg::REFINE_MAX);
      pad    = arpt_pkg::step_up(pad, arpt_pkg::STEP_ONE, arpt_pkg::PAD_MIN,
                                 arpt_pkg::PAD_MAX);
      reuse  = arpt_pkg::step_down(reuse, arpt_pkg::STEP_ONE, arpt_pkg::REUSE_MIN,
                                   arpt_pkg::REUSE_MAX);
    end

    // ROI quality
    if (cls_i.unstable) begin
      hits  = arpt_pkg::step_down(hits, arpt_pkg::STEP_ONE, arpt_pkg::HITS_MIN,
                                  arpt_pkg::HITS_MAX);
      hold  = arpt_pkg::step_up(hold, arpt_pkg::STEP_ONE, arpt_pkg::HOLD_MIN,
                                arpt_pkg::HOLD_MAX);
      pad   = arpt_pkg::step_up(pad, arpt_pkg::STEP_ONE, arpt_pkg::PAD_MIN,
                                arpt_pkg::PAD_MAX);
      chigh = arpt_pkg::step_up(chigh, arpt_pkg::STEP_CONF_UP, arpt_pkg::CHIGH_MIN,
                                arpt_pkg::CHIGH_MAX);
      clow  = arpt_pkg::step_up(clow, arpt_pkg::STEP_CONF, arpt_pkg::CLOW_MIN,
                                arpt_pkg::CLOW_MAX);
    end else if (cls_i.good) begin
      hits  = arpt_pkg::step_up(hits, arpt_pkg::STEP_ONE, arpt_pkg::HITS_MIN,
                                arpt_pkg::HITS_MAX);
      if (hold > arpt_pkg::HOLD_FLOOR) begin
        hold = hold - arpt_pkg::STEP_ONE;
      end
      chigh = arpt_pkg::step_down(chigh, arpt_pkg::STEP_CONF, arpt_pkg::CHIGH_MIN,
                                  arpt_pkg::CHIGH_MAX);
      clow  = arpt_pkg::step_down(clow, arpt_pkg::STEP_CONF, arpt_pkg::CLOW_MIN,
                                  arpt_pkg::CLOW_MAX);
    end

    // Area
    if (cls_i.too_big) begin
      area   = arpt_pkg::step_down(area, arpt_pkg::STEP_AREA_DN, arpt_pkg::AREA_MIN,
                                   arpt_pkg::AREA_MAX);
      pad    = arpt_pkg::step_down(pad, arpt_pkg::STEP_ONE, arpt_pkg::PAD_MIN,
                                   arpt_pkg::PAD_MAX);
      stride = arpt_pkg::step_up(stride, arpt_pkg::STEP_ONE, arpt_pkg::STRIDE_MIN,
                                 arpt_pkg::STRIDE_MAX);
    end else if (cls_i.small_roi) begin
      area   = arpt_pkg::step_up(area, arpt_pkg::STEP_AREA_UP, arpt_pkg::AREA_MIN,
                                 arpt_pkg::AREA_MAX);
    end

    stride = arpt_pkg::sat11(stride, arpt_pkg::STRIDE_MIN, arpt_pkg::STRIDE_MAX);
    coarse = arpt_pkg::sat11(coarse, arpt_pkg::COARSE_MIN, arpt_pkg::COARSE_MAX);
    refine = arpt_pkg::sat11(refine, arpt_pkg::REFINE_MIN, arpt_pkg::REFINE_MAX);
    reuse  = arpt_pkg::sat11(reuse, arpt_pkg::REUSE_MIN, arpt_pkg::REUSE_MAX);
    pad    = arpt_pkg::sat11(pad, arpt_pkg::PAD_MIN, arpt_pkg::PAD_MAX);
    hold   = arpt_pkg::sat11(hold, arpt_pkg::HOLD_MIN, arpt_pkg::HOLD_MAX);
    hits   = arpt_pkg::sat11(hits, arpt_pkg::HITS_MIN, arpt_pkg::HITS_MAX);
    chigh  = arpt_pkg::sat11(chigh, arpt_pkg::CHIGH_MIN, arpt_pkg::CHIGH_MAX);
    // Keep the low confidence at least CONF_GAP under the high one
    if ((clow + arpt_pkg::CONF_GAP) > chigh) begin
      clow = chigh - arpt_pkg::CONF_GAP;
    end
    clow   = arpt_pkg::sat11(clow, arpt_pkg::CLOW_MIN, arpt_pkg::CLOW_MAX);
    area   = arpt_pkg::sat11(area, arpt_pkg::AREA_MIN, arpt_pkg::AREA_MAX);

    vals_d.stride        = stride[3:0];
    vals_d.coarse_every  = coarse[2:0];
    vals_d.refine_every  = refine[2:0];
    vals_d.reuse_limit   = reuse[3:0];
    vals_d.pad_pixels    = pad[4:0];
    vals_d.hold_frames   = hold[4:0];
    vals_d.min_hit_count = hits[5:0];
    vals_d.conf_high     = chigh[9:0];
    vals_d.conf_low      = clow[9:0];
    vals_d.max_area      = area[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vals_q      <= arpt_pkg::VALS_RESET;
      last_time_q <= 48'd0;
    end else if (commit) begin
      vals_q      <= vals_d;
      last_time_q <= time_i;
    end
  end

  assign last_time_o = last_time_q;
  assign vals_next_o = commit ? vals_d : vals_q;

  a_skip_holds_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en_i && !cls_i.apply) |=> $stable(vals_q) && $stable(last_time_q))
    else $error("tuning values moved on a skipped event");

  a_commit_stores_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (last_time_q == $past(time_i)) && (vals_q == $past(vals_d)))
    else $error("applied tune not stored");

endmodule

`default_nettype wire

### rtl/core/adaptive_roi_param_tuner_unit.sv
// ----------------------------------------------------------------------------
// Adaptive ROI parameter tuner
// Retunes ten ROI detection values from a stream of metrics events.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one metrics event per transaction (valid/ready).
//   out_* : one result per event: the applied flag and the tuning values
//           after that event (valid/ready).
//   cfg_* : register writes (index, data); always ready. Write only while
//           no event is in flight.
// Path: each event passes through an input register and a result register.
// Throughput: one event per cycle while out_ready_i is high. Gate,
//   classification and value stepping fit between the two registers; the
//   tuning state is updated in the cycle an event moves into the result
//   register, so the next event sees it.
// Reset: tuning values return to their defaults, the last tune time reads
//   as never tuned, tuner_enable clears, dynamic_enable sets and min_gap_us
//   returns to 1200000. Both pipeline slots empty.
// Stall: while the result waits, one more event is taken into the input
//   register; further events are held off by in_ready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_roi_param_tuner_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  arpt_pkg::arpt_in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output arpt_pkg::arpt_out_t                    out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [arpt_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [arpt_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  arpt_pkg::arpt_cfg_t   cfg_q;
  arpt_pkg::arpt_in_t    in_q;
  arpt_pkg::arpt_out_t   out_q;
  arpt_pkg::arpt_class_t cls;
  arpt_pkg::arpt_vals_t  vals_next;
  logic                  in_valid_q;
  logic                  out_valid_q;
  logic                  advance;
  logic [47:0]           last_time;

  // Move the held event on when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tuner_enable   <= 1'b0;
      cfg_q.dynamic_enable <= 1'b1;
      cfg_q.min_gap_us     <= arpt_pkg::MIN_GAP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        arpt_pkg::REG_TUNER_ENABLE:   cfg_q.tuner_enable   <= cfg_data_i[0];
        arpt_pkg::REG_DYNAMIC_ENABLE: cfg_q.dynamic_enable <= cfg_data_i[0];
        arpt_pkg::REG_MIN_GAP_US:     cfg_q.min_gap_us     <= cfg_data_i;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  arpt_classify u_classify (
    .cfg_i       (cfg_q),
    .last_time_i (last_time),
    .item_i      (in_q),
    .cls_o       (cls)
  );

  arpt_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_en_i    (advance),
    .cls_i       (cls),
    .time_i      (in_q.time_us),
    .last_time_o (last_time),
    .vals_next_o (vals_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.applied       <= cls.apply;
      out_q.stride        <= vals_next.stride;
      out_q.coarse_every  <= vals_next.coarse_every;
      out_q.refine_every  <= vals_next.refine_every;
      out_q.reuse_limit   <= vals_next.reuse_limit;
      out_q.pad_pixels    <= vals_next.pad_pixels;
      out_q.hold_frames   <= vals_next.hold_frames;
      out_q.min_hit_count <= vals_next.min_hit_count;
      out_q.conf_high     <= vals_next.conf_high;
      out_q.conf_low      <= vals_next.conf_low;
      out_q.max_area      <= vals_next.max_area;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with an empty result register");

  a_conf_margin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.conf_low} + 11'd80) <= {1'b0, out_data_o.conf_high})
    else $error("confidence margin lost");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.stride >= 4'd2) && (out_data_o.stride <= 4'd8) &&
                    (out_data_o.pad_pixels >= 5'd2) && (out_data_o.pad_pixels <= 5'd28) &&
                    (out_data_o.max_area >= 10'd200) && (out_data_o.max_area <= 10'd800))
    else $error("tuning value out of bounds");

  a_result_follows_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && (out_q.applied == $past(cls.apply)))
    else $error("result register not loaded from the held event");

endmodule

`default_nettype wire
